// ===== hdl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion wrappers used by the RTL; empty when synthesizing.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Check prop at every rising clock edge, masked while rst is high.
`define RAFC_ASSERT(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("rafc assertion failed");
// Check prop at every rising clock edge, reset included.
`define RAFC_ASSERT_ALWAYS(label, clk, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("rafc assertion failed");
`else
`define RAFC_ASSERT(label, clk, rst, prop)
`define RAFC_ASSERT_ALWAYS(label, clk, prop)
`endif
`endif

// ===== hdl/rafc_pkg.sv =====
// ----------------------------------------------------------------------------
// rafc_pkg
// Types, framing constants and hex decode for the RFID ASCII frame checker.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
package rafc_pkg;

  typedef logic [39:0] tag_t;
  typedef logic [7:0]  byte_t;
  typedef logic [1:0]  status_t;
  typedef logic [1:0]  cfg_index_t;
  typedef logic [3:0]  char_pos_t;

  localparam byte_t START_BYTE = 8'h02;
  localparam byte_t END_BYTE   = 8'h0D;
  localparam byte_t CHAR_ZERO  = 8'h30;
  localparam byte_t CHAR_NINE  = 8'h39;
  localparam byte_t CHAR_UPPER_A = 8'h41;
  localparam byte_t CHAR_UPPER_F = 8'h46;
  localparam byte_t BAD_NIBBLE = 8'hFF;

  // twelve hex characters per frame, the first ten carry the tag
  localparam char_pos_t HEX_CHARS = 4'd12;
  localparam char_pos_t TAG_CHARS = 4'd10;

  localparam status_t STATUS_OK       = 2'd0;
  localparam status_t STATUS_CSUM_ERR = 2'd1;
  localparam status_t STATUS_FMT_ERR  = 2'd2;

  localparam cfg_index_t REG_MASTER_ONE = 2'd0;
  localparam cfg_index_t REG_MASTER_TWO = 2'd1;

  localparam tag_t MASTER_ONE_RESET = 40'h010B763AB4;
  localparam tag_t MASTER_TWO_RESET = 40'h010B7641E8;

  // ASCII hex digit to nibble; anything else decodes as all ones
  function automatic byte_t hex_nibble(input byte_t c);
    byte_t n;
    n = BAD_NIBBLE;
    if (c >= CHAR_ZERO && c <= CHAR_NINE) begin
      n = c - CHAR_ZERO;
    end else if (c >= CHAR_UPPER_A && c <= CHAR_UPPER_F) begin
      n = c - CHAR_UPPER_A + 8'd10;
    end
    return n;
  endfunction

endpackage

// ===== hdl/rafc_byte_if.sv =====
// ----------------------------------------------------------------------------
// rafc_byte_if
// Valid/ready channel carrying one received byte.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
interface rafc_byte_if;
  logic              valid;
  logic              ready;
  rafc_pkg::byte_t   rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

// ===== hdl/rafc_frame_if.sv =====
// ----------------------------------------------------------------------------
// rafc_frame_if
// Valid/ready channel carrying one checked frame report.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
interface rafc_frame_if;
  logic              valid;
  logic              ready;
  rafc_pkg::tag_t    tag_id;
  rafc_pkg::byte_t   received_checksum;
  rafc_pkg::byte_t   computed_checksum;
  rafc_pkg::status_t frame_status;
  logic              red_level;
  logic              green_level;

  modport source (output valid, output tag_id, output received_checksum,
                  output computed_checksum, output frame_status,
                  output red_level, output green_level, input ready);
  modport sink   (input valid, input tag_id, input received_checksum,
                  input computed_checksum, input frame_status,
                  input red_level, input green_level, output ready);
endinterface

// ===== hdl/rafc_cfg_if.sv =====
// ----------------------------------------------------------------------------
// rafc_cfg_if
// Register write channel: index and data under valid/ready.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
interface rafc_cfg_if;
  logic                 valid;
  logic                 ready;
  rafc_pkg::cfg_index_t index;
  rafc_pkg::tag_t       data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== hdl/rfid_ascii_frame_checker.sv =====
// ----------------------------------------------------------------------------
// rfid_ascii_frame_checker
// Frame parser and XOR checksum checker for an ASCII hex RFID reader stream.
// ----------------------------------------------------------------------------
// Feed the reader's raw bytes on rx, one request per byte. Outside a frame
// every byte but 0x02 is dropped. After 0x02 come twelve hex characters
// ('0'-'9', 'A'-'F'; anything else counts as nibble F-all-ones) forming five
// tag bytes and a checksum byte, then the end byte 0x0D. The fourteenth byte
// yields one report on frame: status ok, checksum error, or format error
// (end byte wrong, tag and checksums reported as zero). On ok, red follows
// tag == master one and green follows tag == master two; otherwise the
// levels are held. Each byte makes a single registered pass: a byte register
// feeds the decode/state update, which loads the report register, so one
// byte per clock is sustained unless an end byte waits on an untaken report,
// stalling it and the bytes behind it. The user must write master tags on cfg
// (index 0/1, others ignored) only while idle; the block does not enforce it.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"
module rfid_ascii_frame_checker (
  input  logic clk,
  input  logic rst,
  rafc_byte_if.sink    rx,
  rafc_frame_if.source frame,
  rafc_cfg_if.sink     cfg
);
  import rafc_pkg::*;

  // master tags
  tag_t master_one;
  tag_t master_two;

  // byte register in front of the parser
  logic  byte_valid;
  byte_t byte_hold;

  // frame state
  logic      in_frame;
  char_pos_t char_pos;
  logic [3:0] high_nibble;
  tag_t      tag_shift;
  byte_t     checksum_hold;
  byte_t     running_xor;
  logic      red_state;
  logic      green_state;

  // report register
  logic res_valid;

  logic   at_end;
  logic   advance;
  byte_t  nibble;
  byte_t  pair_value;
  logic   end_ok;
  logic   csum_match;
  logic   red_next;
  logic   green_next;

  // configuration: always ready, write on request
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      master_one <= MASTER_ONE_RESET;
      master_two <= MASTER_TWO_RESET;
    end else if (cfg.valid) begin
      case (cfg.index)
        REG_MASTER_ONE: master_one <= cfg.data;
        REG_MASTER_TWO: master_two <= cfg.data;
        default: ;
      endcase
    end
  end

  // the end byte is the only byte that produces a report; it must wait for
  // the report register, everything else advances unconditionally
  assign at_end  = in_frame && (char_pos == HEX_CHARS);
  assign advance = byte_valid && (!at_end || !res_valid || frame.ready);
  assign rx.ready = !byte_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_valid <= 1'b0;
    end else if (rx.ready) begin
      byte_valid <= rx.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rx.ready && rx.valid) begin
      byte_hold <= rx.rx_byte;
    end
  end

  // decode: pair byte keeps the 8-bit truncation, so a bad high character
  // contributes F0 and a bad low character forces FF
  assign nibble     = hex_nibble(byte_hold);
  assign pair_value = {high_nibble, 4'h0} | nibble;
  assign end_ok     = (byte_hold == END_BYTE);
  assign csum_match = (checksum_hold == running_xor);
  assign red_next   = (end_ok && csum_match) ? (tag_shift == master_one) : red_state;
  assign green_next = (end_ok && csum_match) ? (tag_shift == master_two) : green_state;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_frame      <= 1'b0;
      char_pos      <= '0;
      high_nibble   <= '0;
      tag_shift     <= '0;
      checksum_hold <= '0;
      running_xor   <= '0;
      red_state     <= 1'b0;
      green_state   <= 1'b0;
    end else if (advance) begin
      if (!in_frame) begin
        // hunt for the start byte
        if (byte_hold == START_BYTE) begin
          in_frame      <= 1'b1;
          char_pos      <= '0;
          high_nibble   <= '0;
          tag_shift     <= '0;
          checksum_hold <= '0;
          running_xor   <= '0;
        end
      end else if (!at_end) begin
        char_pos <= char_pos + 4'd1;
        if (!char_pos[0]) begin
          high_nibble <= nibble[3:0];
        end else if (char_pos < TAG_CHARS) begin
          tag_shift   <= {tag_shift[31:0], pair_value};
          running_xor <= running_xor ^ pair_value;
        end else begin
          checksum_hold <= pair_value;
        end
      end else begin
        // end byte: report, update levels, back to idle
        red_state     <= red_next;
        green_state   <= green_next;
        in_frame      <= 1'b0;
        char_pos      <= '0;
        high_nibble   <= '0;
        tag_shift     <= '0;
        checksum_hold <= '0;
        running_xor   <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (advance && at_end) begin
      res_valid <= 1'b1;
    end else if (frame.ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && at_end) begin
      frame.red_level   <= red_next;
      frame.green_level <= green_next;
      if (end_ok) begin
        frame.tag_id            <= tag_shift;
        frame.received_checksum <= checksum_hold;
        frame.computed_checksum <= running_xor;
        frame.frame_status      <= csum_match ? STATUS_OK : STATUS_CSUM_ERR;
      end else begin
        frame.tag_id            <= '0;
        frame.received_checksum <= '0;
        frame.computed_checksum <= '0;
        frame.frame_status      <= STATUS_FMT_ERR;
      end
    end
  end

  assign frame.valid = res_valid;

  `RAFC_ASSERT(a_pos_range, clk, rst, char_pos <= HEX_CHARS)
  `RAFC_ASSERT(a_idle_pos_zero, clk, rst, !in_frame |-> char_pos == '0)
  `RAFC_ASSERT(a_ok_match, clk, rst,
               res_valid && frame.frame_status == STATUS_OK |->
               frame.received_checksum == frame.computed_checksum)
  `RAFC_ASSERT(a_fmt_zero, clk, rst,
               res_valid && frame.frame_status == STATUS_FMT_ERR |->
               frame.tag_id == '0 && frame.computed_checksum == '0)
  `RAFC_ASSERT(a_report_from_end, clk, rst, advance && !at_end |=> !$rose(res_valid))
  `RAFC_ASSERT_ALWAYS(a_reset_idle, clk, rst |=> !res_valid && !in_frame && !byte_valid)

endmodule
